FILE: rtl/u8u16_pkg.sv
`timescale 1ns / 1ps

package u8u16_pkg;

    localparam logic [15:0] REPL_UNIT   = 16'hFFFD;
    localparam logic [20:0] CP_MAX      = 21'h10FFFF;
    localparam logic [20:0] SURR_LO     = 21'h00D800;
    localparam logic [20:0] SURR_HI     = 21'h00DFFF;
    localparam logic [20:0] SUPP_BASE   = 21'h010000;
    localparam logic [15:0] HI_BASE     = 16'hD800;
    localparam logic [15:0] LO_BASE     = 16'hDC00;
    localparam logic [9:0]  LO_MASK     = 10'h3FF;
    localparam logic [20:0] MIN_2B      = 21'h000080;
    localparam logic [20:0] MIN_3B      = 21'h000800;
    localparam logic [20:0] MIN_4B      = 21'h010000;

    localparam int          PEND_DEPTH  = 4;
    localparam int          RES_DEPTH   = 3;
    localparam logic [1:0]  RES_FULL    = 2'd3;

    typedef logic [PEND_DEPTH-1:0][7:0] t_pend;

    typedef struct packed {
        logic        stall;
        logic [2:0]  used;
        logic        pair;
        logic [15:0] unit0;
        logic [15:0] unit1;
    } t_step;

    typedef struct packed {
        logic        clr;
        logic        wr;
        logic        emit;
        logic        last;
    } t_q_ctrl;

    typedef struct packed {
        logic        empty;
        logic        done;
    } t_q_stat;

endpackage

FILE: rtl/utf8_to_utf16_decoder_top.sv
`timescale 1ns / 1ps

// UTF-8 to UTF-16 transcoder.
// Slave channel: one UTF-8 byte per transaction on s_axis_tdata, s_axis_tlast
// marks the final byte of the stream. Master channel: one UTF-16 code unit per
// transaction; m_axis_tlast marks the final unit caused by an input byte and
// m_axis_tuser marks the final unit of the whole stream. Bytes that cause no
// unit produce no master transaction.
// The block takes one byte, then works on it alone. A single decode unit judges
// the sequence at the head of a four-byte holding buffer, one sequence at a
// time, writes the low half of a surrogate pair in a state of its own, and
// finds the buffer empty or waiting before it stops. Up to three units are
// collected and then sent one per cycle while the receiver is ready. The next
// byte is taken only after the last unit of the current one has been sent.
// Reset empties the holding buffer and the result queue; s_axis_tready is high
// after reset. While the receiver stalls, the current unit holds on the master
// channel and no new byte is taken.
module utf8_to_utf16_decoder_top
    import u8u16_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // byte_req
    input  logic        s_axis_tlast,   // last_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // code_unit
    output logic        m_axis_tlast,   // run_end
    output logic        m_axis_tuser    // stream_end
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_DEC  = 4'b0010,
        ST_PAIR = 4'b0100,
        ST_EMIT = 4'b1000
    } t_state;

    t_state      r_state, n_state;
    t_pend       r_pend, n_pend;
    logic [2:0]  r_cnt, n_cnt;
    logic        r_last, n_last;
    logic [15:0] r_lo, n_lo;

    t_step       step;
    t_q_ctrl     qc;
    t_q_stat     qs;
    logic [15:0] q_data;
    logic        in_xfer;

    u8u16_step u_step (
        .i_pend (r_pend),
        .i_cnt  (r_cnt),
        .i_last (r_last),
        .o_step (step)
    );

    u8u16_resq u_resq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctrl        (qc),
        .i_wr_data     (q_data),
        .o_stat        (qs),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_xfer       = s_axis_tvalid & s_axis_tready;

    always_comb begin
        n_state = r_state;
        n_pend  = r_pend;
        n_cnt   = r_cnt;
        n_last  = r_last;
        n_lo    = r_lo;
        qc      = '0;
        qc.last = r_last;
        q_data  = step.unit0;

        case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    qc.clr = 1'b1;
                    n_last = s_axis_tlast;
                    if (!r_cnt[2]) begin
                        n_pend[r_cnt[1:0]] = s_axis_tdata;
                        n_cnt              = r_cnt + 3'd1;
                    end
                    n_state = ST_DEC;
                end
            end
            ST_DEC: begin
                if ((r_cnt == 3'd0) || step.stall) begin
                    n_state = qs.empty ? ST_IDLE : ST_EMIT;
                end else begin
                    qc.wr = 1'b1;
                    n_cnt = r_cnt - step.used;
                    case (step.used)
                        3'd1:    n_pend = {r_pend[3], r_pend[3:1]};
                        3'd2:    n_pend = {r_pend[3:2], r_pend[3:2]};
                        3'd3:    n_pend = {r_pend[3:1], r_pend[3]};
                        default: n_pend = r_pend;
                    endcase
                    if (step.pair) begin
                        n_lo    = step.unit1;
                        n_state = ST_PAIR;
                    end
                end
            end
            ST_PAIR: begin
                qc.wr   = 1'b1;
                q_data  = r_lo;
                n_state = ST_DEC;
            end
            ST_EMIT: begin
                qc.emit = 1'b1;
                if (qs.done) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_last  <= n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend <= n_pend;
        r_lo   <= n_lo;
    end

`ifndef SYNTHESIS
    a_held_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (r_cnt <= 3'd3))
        else $error("holding buffer over three bytes while idle");

    a_drain_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_IDLE) && r_last) |-> (r_cnt == 3'd0))
        else $error("bytes left after end of stream");

    a_sides_apart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input ready while results pending");

    a_emit_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> !qs.empty)
        else $error("emitting from empty result queue");
`endif

endmodule

FILE: rtl/u8u16_step.sv
`timescale 1ns / 1ps

module u8u16_step
    import u8u16_pkg::*;
(
    input  t_pend      i_pend,
    input  logic [2:0] i_cnt,
    input  logic       i_last,
    output t_step      o_step
);

    logic [7:0]  b0;
    logic [2:0]  c_ok;
    logic [1:0]  extra;
    logic [20:0] cp;
    logic [20:0] minv;
    logic [20:0] v;
    logic        bad_seq;
    logic        out_rng;

    always_comb begin
        b0      = i_pend[0];
        c_ok[0] = (i_pend[1][7:6] == 2'b10);
        c_ok[1] = (i_pend[2][7:6] == 2'b10);
        c_ok[2] = (i_pend[3][7:6] == 2'b10);

        extra = 2'd0;
        minv  = '0;
        if (b0[7:5] == 3'b110) begin
            extra = 2'd1;
            minv  = MIN_2B;
        end else if (b0[7:4] == 4'b1110) begin
            extra = 2'd2;
            minv  = MIN_3B;
        end else if (b0[7:3] == 5'b11110) begin
            extra = 2'd3;
            minv  = MIN_4B;
        end

        case (extra)
            2'd1:    cp = {10'd0, b0[4:0], i_pend[1][5:0]};
            2'd2:    cp = {5'd0, b0[3:0], i_pend[1][5:0], i_pend[2][5:0]};
            2'd3:    cp = {b0[2:0], i_pend[1][5:0], i_pend[2][5:0], i_pend[3][5:0]};
            default: cp = {13'd0, b0};
        endcase

        out_rng = (cp < minv) || (cp > CP_MAX) || ((cp >= SURR_LO) && (cp <= SURR_HI));

        o_step.stall = 1'b0;
        o_step.used  = {1'b0, extra} + 3'd1;
        bad_seq      = 1'b0;

        if (b0[7] == 1'b0) begin
            o_step.used = 3'd1;
        end else if (extra == 2'd0) begin
            bad_seq     = 1'b1;
            o_step.used = 3'd1;
        end else if (i_cnt <= {1'b0, extra}) begin
            o_step.stall = !i_last;
            bad_seq      = 1'b1;
            o_step.used  = 3'd1;
        end else if (!c_ok[0]) begin
            bad_seq     = 1'b1;
            o_step.used = 3'd2;
        end else if ((extra != 2'd1) && !c_ok[1]) begin
            bad_seq     = 1'b1;
            o_step.used = 3'd3;
        end else if ((extra == 2'd3) && !c_ok[2]) begin
            bad_seq     = 1'b1;
            o_step.used = 3'd4;
        end else if (out_rng) begin
            bad_seq     = 1'b1;
        end

        v = cp - SUPP_BASE;
        if (bad_seq) begin
            o_step.pair  = 1'b0;
            o_step.unit0 = REPL_UNIT;
        end else if (cp[20:16] != 5'd0) begin
            o_step.pair  = 1'b1;
            o_step.unit0 = HI_BASE + {6'd0, v[19:10]};
        end else begin
            o_step.pair  = 1'b0;
            o_step.unit0 = cp[15:0];
        end
        o_step.unit1 = LO_BASE + {6'd0, v[9:0] & LO_MASK};
    end

endmodule

FILE: rtl/u8u16_resq.sv
`timescale 1ns / 1ps

module u8u16_resq
    import u8u16_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_q_ctrl     i_ctrl,
    input  logic [15:0] i_wr_data,
    output t_q_stat     o_stat,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,  // code_unit
    output logic        m_axis_tlast,  // run_end
    output logic        m_axis_tuser   // stream_end
);

    logic [15:0] r_mem [RES_DEPTH];
    logic [1:0]  r_n;
    logic [1:0]  r_rd;
    logic        xfer;

    assign m_axis_tvalid = i_ctrl.emit;
    assign m_axis_tdata  = r_mem[r_rd];
    assign m_axis_tlast  = (r_rd == r_n - 2'd1);
    assign m_axis_tuser  = m_axis_tlast & i_ctrl.last;
    assign xfer          = m_axis_tvalid & m_axis_tready;

    assign o_stat.empty  = (r_n == 2'd0);
    assign o_stat.done   = xfer & m_axis_tlast;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n  <= '0;
            r_rd <= '0;
        end else if (i_ctrl.clr) begin
            r_n  <= '0;
            r_rd <= '0;
        end else begin
            if (i_ctrl.wr && (r_n != RES_FULL)) begin
                r_n <= r_n + 2'd1;
            end
            if (xfer) begin
                r_rd <= r_rd + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.wr && !i_ctrl.clr && (r_n != RES_FULL)) begin
            r_mem[r_n] <= i_wr_data;
        end
    end

endmodule
